>>> rtl/core/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg
// Shared types, constants and field helpers for the alpha premultiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pap_pkg;

    // Pixel word width inside the datapath (16..64)
    localparam int PIXEL_WIDTH = 32;

    // Port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Per-lane stage count: product, rounding, 8 divide stages, write back
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES         = 32 / DIV_BITS_PER_STAGE;
    localparam int LANE_STAGES        = DIV_STAGES + 3;
    localparam int LANE_LAST          = LANE_STAGES - 1;
    localparam int NUM_LANES          = 3;

    // Whole pipeline: input, alpha, three color lanes, output
    localparam int PIPE_DEPTH = 2 + NUM_LANES * LANE_STAGES + 1;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

    // 16-bit level constants
    localparam logic [15:0] FULL16 = 16'hFFFF;
    localparam logic [15:0] HALF16 = 16'h7FFF;

    // Mode codes; the unused code reads alpha too
    localparam logic [1:0] MODE_PREMUL   = 2'd0;
    localparam logic [1:0] MODE_OPAQUE   = 2'd1;
    localparam logic [1:0] MODE_READ     = 2'd2;

    // Lane codes
    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA_MASK  = 4'd0,
        REG_ALPHA_SHIFT = 4'd1,
        REG_RED_MASK    = 4'd2,
        REG_RED_SHIFT   = 4'd3,
        REG_GREEN_MASK  = 4'd4,
        REG_GREEN_SHIFT = 4'd5,
        REG_BLUE_MASK   = 4'd6,
        REG_BLUE_SHIFT  = 4'd7
    } cfg_reg_e;

    // Field layout
    typedef struct packed {
        logic [15:0]                amask;
        logic [4:0]                 ashift;
        logic [NUM_LANES-1:0][15:0] cmask;
        logic [NUM_LANES-1:0][4:0]  cshift;
    } cfg_t;

    // One pixel in flight, with divider working registers
    typedef struct packed {
        logic [1:0]             mode;
        logic [PIXEL_WIDTH-1:0] pix;
        logic [15:0]            level;
        logic [15:0]            a;
        logic [31:0]            num;
        logic [16:0]            rem;
        logic [15:0]            dvs;
        logic [15:0]            alpha_out;
    } item_t;

    function automatic logic is_read(logic [1:0] mode);
        return mode >= MODE_READ;
    endfunction

    // Right-aligned field read
    function automatic logic [15:0] get_field(logic [PIXEL_WIDTH-1:0] p,
                                              logic [15:0] m, logic [4:0] s);
        logic [63:0] p64;
        p64 = 64'(p) >> s;
        return p64[15:0] & m;
    endfunction

    // Field write, clipped to the pixel width
    function automatic logic [PIXEL_WIDTH-1:0] put_field(logic [PIXEL_WIDTH-1:0] p,
                                                         logic [15:0] m, logic [4:0] s,
                                                         logic [15:0] v);
        logic [63:0] p64;
        logic [63:0] m64;
        logic [63:0] v64;
        p64 = 64'(p);
        m64 = 64'(m) << s;
        v64 = 64'(v & m) << s;
        p64 = (p64 & ~m64) | v64;
        return p64[PIXEL_WIDTH-1:0];
    endfunction

    // x / 65535 for x below 65536 * 65535
    function automatic logic [15:0] div_full16(logic [31:0] x);
        logic [16:0] q0;
        logic [16:0] r;
        logic [16:0] q;
        q0 = {1'b0, x[31:16]};
        r  = {1'b0, x[15:0]} + q0;
        if (r >= 17'd131070)
            q = q0 + 17'd2;
        else if (r >= 17'(FULL16))
            q = q0 + 17'd1;
        else
            q = q0;
        return q[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pap_intf.sv
// ----------------------------------------------------------------------------
// pap_intf
// Valid/ready stream interfaces for pixel input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface pap_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] pixel_in;
    logic [15:0] alpha_level;

    modport source (output valid, mode, pixel_in, alpha_level, input ready);
    modport sink   (input valid, mode, pixel_in, alpha_level, output ready);
endinterface

interface pap_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic [15:0] alpha_out;

    modport source (output valid, pixel_out, alpha_out, input ready);
    modport sink   (input valid, pixel_out, alpha_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pap_color_lane.sv
// ----------------------------------------------------------------------------
// pap_color_lane
// One color field: product, rounding, pipelined 32/16 divide, field write.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_color_lane (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pap_pkg::cfg_t cfg,
    input  wire logic [1:0]    lane,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pap_pkg::item_t in_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pap_pkg::item_t     out_item
);

    // Work done by stage k of the lane
    function automatic pap_pkg::item_t lane_op(int k, pap_pkg::item_t x,
                                               pap_pkg::cfg_t c, logic [15:0] m,
                                               logic [4:0] s, logic is_red);
        pap_pkg::item_t y;
        logic [15:0]    fv;
        logic [15:0]    qs;
        logic [16:0]    r;
        logic           apply;
        y = x;
        apply = (c.amask != 16'd0) && (m != 16'd0) &&
                ((x.mode == pap_pkg::MODE_PREMUL) ||
                 ((x.mode == pap_pkg::MODE_OPAQUE) && (x.a != 16'd0) &&
                  (x.a != c.amask)));
        case (k)
            0:
            begin
                fv = pap_pkg::get_field(x.pix, m, s);
                if (pap_pkg::is_read(x.mode))
                    y.num = {x.a, 16'd0} - 32'(x.a);
                else if (x.mode == pap_pkg::MODE_OPAQUE)
                    y.num = 32'(fv) * 32'(c.amask);
                else
                    y.num = 32'(fv) * 32'(x.a);
            end
            1:
            begin
                y.rem = '0;
                if (x.mode == pap_pkg::MODE_OPAQUE)
                begin
                    y.num = x.num + 32'(x.a >> 1);
                    y.dvs = x.a;
                end
                else
                begin
                    y.num = x.num + 32'(c.amask >> 1);
                    y.dvs = c.amask;
                end
            end
            pap_pkg::LANE_LAST:
            begin
                if (x.mode == pap_pkg::MODE_OPAQUE && x.num > 32'(m))
                    qs = m;
                else
                    qs = x.num[15:0];
                if (apply)
                    y.pix = pap_pkg::put_field(x.pix, m, s, qs);
                if (pap_pkg::is_read(x.mode) && is_red)
                    y.alpha_out = x.num[15:0];
            end
            default:
            begin
                // restoring divide, a few quotient bits per stage
                for (int j = 0; j < pap_pkg::DIV_BITS_PER_STAGE; j++)
                begin
                    r = {y.rem[15:0], y.num[31]};
                    y.num = {y.num[30:0], 1'b0};
                    if (r >= 17'(y.dvs))
                    begin
                        r = r - 17'(y.dvs);
                        y.num[0] = 1'b1;
                    end
                    y.rem = r;
                end
            end
        endcase
        return y;
    endfunction

    pap_pkg::item_t                          item_reg  [pap_pkg::LANE_STAGES];
    pap_pkg::item_t                          item_next [pap_pkg::LANE_STAGES];
    logic [pap_pkg::LANE_STAGES-1:0]         v_reg;
    logic [pap_pkg::LANE_STAGES-1:0]         v_next;
    logic [pap_pkg::LANE_STAGES:0]           rdy;
    logic [15:0]                             m_sel;
    logic [4:0]                              s_sel;

    assign m_sel = cfg.cmask[lane];
    assign s_sel = cfg.cshift[lane];

    assign rdy[pap_pkg::LANE_STAGES] = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[pap_pkg::LANE_LAST];
    assign out_item  = item_reg[pap_pkg::LANE_LAST];

    for (genvar k = 0; k < pap_pkg::LANE_STAGES; k++)
    begin : g_stage
        logic           src_v;
        pap_pkg::item_t src_item;

        if (k == 0)
        begin : g_first
            assign src_v    = in_valid;
            assign src_item = in_item;
        end
        else
        begin : g_rest
            assign src_v    = v_reg[k-1];
            assign src_item = item_reg[k-1];
        end

        // a stage takes a beat when empty or when its beat moves on
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            v_next[k]    = rdy[k] ? src_v : v_reg[k];
            item_next[k] = lane_op(k, src_item, cfg, m_sel, s_sel, lane == pap_pkg::LANE_RED);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_next[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_v)
                item_reg[k] <= item_next[k];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pixel_alpha_premultiply_unit.sv
// ----------------------------------------------------------------------------
// pixel_alpha_premultiply_unit
// Sets, removes or reads premultiplied alpha on packed pixels with a
// configurable field layout.
//
//   channel   dir  beat payload                       handshake
//   pix_in    in   mode, pixel_in, alpha_level        valid/ready
//   pix_out   out  pixel_out, alpha_out               valid/ready
//   cfg       in   cfg_idx, cfg_wdata                 cfg_we, no wait
//
// One beat per clock sustained while pix_out stays ready; 36 register stages:
// input capture, alpha, the three color lanes and the output register.
// Depth is set by the three color lanes in series, each with an 8-stage
// 32/16 divider (4 quotient bits per stage).
// Every stage holds its own beat: a stall at pix_out fills empty stages
// first, so input keeps flowing until the whole pipe is full.
// Reset clears all valid bits and loads the default 8-bit ARGB layout.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_alpha_premultiply_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pap_in_if.sink                                 pix_in,
    pap_out_if.source                              pix_out,
    input  wire logic                              cfg_we,
    input  wire logic [pap_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [pap_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    pap_pkg::cfg_t  cfg_reg;
    pap_pkg::cfg_t  cfg_next;

    pap_pkg::item_t s0_reg, s0_next;
    pap_pkg::item_t s1_reg, s1_next;
    pap_pkg::item_t f_reg,  f_next;
    logic           s0_v_reg, s0_v_next;
    logic           s1_v_reg, s1_v_next;
    logic           f_v_reg,  f_v_next;
    logic           s0_rdy, s1_rdy, f_rdy;

    pap_pkg::item_t lane_item [pap_pkg::NUM_LANES+1];
    logic           lane_v    [pap_pkg::NUM_LANES+1];
    logic           lane_rdy  [pap_pkg::NUM_LANES+1];

    logic [63:0]    pin64;
    logic [63:0]    pout64;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                pap_pkg::REG_ALPHA_MASK:  cfg_next.amask     = cfg_wdata;
                pap_pkg::REG_ALPHA_SHIFT: cfg_next.ashift    = cfg_wdata[4:0];
                pap_pkg::REG_RED_MASK:    cfg_next.cmask[0]  = cfg_wdata;
                pap_pkg::REG_RED_SHIFT:   cfg_next.cshift[0] = cfg_wdata[4:0];
                pap_pkg::REG_GREEN_MASK:  cfg_next.cmask[1]  = cfg_wdata;
                pap_pkg::REG_GREEN_SHIFT: cfg_next.cshift[1] = cfg_wdata[4:0];
                pap_pkg::REG_BLUE_MASK:   cfg_next.cmask[2]  = cfg_wdata;
                pap_pkg::REG_BLUE_SHIFT:  cfg_next.cshift[2] = cfg_wdata[4:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amask     <= 16'd255;
            cfg_reg.ashift    <= 5'd24;
            cfg_reg.cmask[0]  <= 16'd255;
            cfg_reg.cshift[0] <= 5'd16;
            cfg_reg.cmask[1]  <= 16'd255;
            cfg_reg.cshift[1] <= 5'd8;
            cfg_reg.cmask[2]  <= 16'd255;
            cfg_reg.cshift[2] <= 5'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Ready chain
    assign f_rdy  = !f_v_reg || pix_out.ready;
    assign s1_rdy = !s1_v_reg || lane_rdy[0];
    assign s0_rdy = !s0_v_reg || s1_rdy;
    assign pix_in.ready = s0_rdy;

    // Stage 0: capture beat, level times alpha mask
    assign pin64 = 64'(pix_in.pixel_in);

    always_comb
    begin
        s0_v_next       = s0_rdy ? pix_in.valid : s0_v_reg;
        s0_next         = '0;
        s0_next.mode    = pix_in.mode;
        s0_next.pix     = pin64[pap_pkg::PIXEL_WIDTH-1:0];
        s0_next.level   = pix_in.alpha_level;
        s0_next.num     = 32'(pix_in.alpha_level) * 32'(cfg_reg.amask);
    end

    // Stage 1: alpha value; in premultiply mode it goes into the pixel first
    always_comb
    begin
        s1_v_next = s1_rdy ? s0_v_reg : s1_v_reg;
        s1_next   = s0_reg;
        if (s0_reg.mode == pap_pkg::MODE_PREMUL)
        begin
            s1_next.a = pap_pkg::div_full16(s0_reg.num + 32'(pap_pkg::HALF16));
            if (cfg_reg.amask != 16'd0)
                s1_next.pix = pap_pkg::put_field(s0_reg.pix, cfg_reg.amask,
                                                 cfg_reg.ashift, s1_next.a);
        end
        else
        begin
            s1_next.a = pap_pkg::get_field(s0_reg.pix, cfg_reg.amask, cfg_reg.ashift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            f_v_reg  <= 1'b0;
        end
        else
        begin
            s0_v_reg <= s0_v_next;
            s1_v_reg <= s1_v_next;
            f_v_reg  <= f_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_rdy && pix_in.valid)
            s0_reg <= s0_next;
        if (s1_rdy && s0_v_reg)
            s1_reg <= s1_next;
        if (f_rdy && lane_v[pap_pkg::NUM_LANES])
            f_reg <= f_next;
    end

    // Color lanes in field order: red, green, blue
    assign lane_item[0] = s1_reg;
    assign lane_v[0]    = s1_v_reg;
    assign lane_rdy[pap_pkg::NUM_LANES] = f_rdy;

    for (genvar i = 0; i < pap_pkg::NUM_LANES; i++)
    begin : g_lane
        pap_color_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg_reg),
            .lane      (2'(i)),
            .in_valid  (lane_v[i]),
            .in_ready  (lane_rdy[i]),
            .in_item   (lane_item[i]),
            .out_valid (lane_v[i+1]),
            .out_ready (lane_rdy[i+1]),
            .out_item  (lane_item[i+1])
        );
    end

    // Output stage: opaque alpha write, no-alpha read value
    always_comb
    begin
        f_v_next = f_rdy ? lane_v[pap_pkg::NUM_LANES] : f_v_reg;
        f_next   = lane_item[pap_pkg::NUM_LANES];
        if (cfg_reg.amask != 16'd0 && f_next.mode == pap_pkg::MODE_OPAQUE)
            f_next.pix = pap_pkg::put_field(f_next.pix, cfg_reg.amask,
                                            cfg_reg.ashift, cfg_reg.amask);
        if (cfg_reg.amask == 16'd0 && pap_pkg::is_read(f_next.mode))
            f_next.alpha_out = pap_pkg::FULL16;
    end

    assign pout64            = 64'(f_reg.pix);
    assign pix_out.valid     = f_v_reg;
    assign pix_out.pixel_out = pout64[31:0];
    assign pix_out.alpha_out = f_reg.alpha_out;

    // level is consumed in stage 0 only
    logic unused_level;
    assign unused_level = ^f_reg.level ^ ^f_reg.rem ^ ^f_reg.dvs ^ ^f_reg.num ^ ^f_reg.a;

endmodule

`default_nettype wire

>>> rtl/core/pap_checker.sv
// ----------------------------------------------------------------------------
// pap_port_checks
// Port-level checks on the premultiply unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pap_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] pixel_out,
    input wire logic [15:0] alpha_out
);

    logic [pap_pkg::OCC_W-1:0] occ_reg;
    logic [pap_pkg::OCC_W-1:0] occ_next;

    // Beats inside the unit
    always_comb
    begin
        occ_next = occ_reg;
        if (in_valid && in_ready)
            occ_next = occ_next + pap_pkg::OCC_W'(1);
        if (out_valid && out_ready)
            occ_next = occ_next - pap_pkg::OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out) && $stable(alpha_out))
        else $error("result payload changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("result beat without an accepted input");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> in_ready)
        else $error("empty pipe refuses input");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= pap_pkg::OCC_W'(pap_pkg::PIPE_DEPTH))
        else $error("more beats in flight than pipe stages");

endmodule

bind pixel_alpha_premultiply_unit pap_port_checks u_pap_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .pixel_out (pix_out.pixel_out),
    .alpha_out (pix_out.alpha_out)
);

`default_nettype wire
